FILE: design/bpt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bpt_pkg
// Shared types, codes and vertex tables of the bilinear patch tessellator.
// ----------------------------------------------------------------------------
package bpt_pkg;

	localparam int MAX_GRID     = 256;
	localparam int NUM_VERTS    = 6;
	localparam int PAIR_STEPS   = 6;   // e0/e1 blends of three axes
	localparam int ISSUE_STEPS  = 9;   // plus the three x-direction blends

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_CELL = 1'b1;

	localparam logic CFG_GRID_COLS = 1'b0;
	localparam logic CFG_GRID_ROWS = 1'b1;

	localparam logic [1:0] CORNER_00 = 2'd0;
	localparam logic [1:0] CORNER_10 = 2'd1;
	localparam logic [1:0] CORNER_01 = 2'd2;
	localparam logic [1:0] CORNER_11 = 2'd3;

	// grid offsets of the six vertices, bit k is vertex k
	localparam logic [5:0] ODD_DC  = 6'b010110;
	localparam logic [5:0] ODD_DR  = 6'b110100;
	localparam logic [5:0] EVEN_DC = 6'b110100;
	localparam logic [5:0] EVEN_DR = 6'b101001;

	typedef enum logic [1:0] {
		KIND_E0    = 2'd0,
		KIND_E1    = 2'd1,
		KIND_FINAL = 2'd2
	} lerp_kind_t;

	typedef enum logic [1:0] {
		AXIS_X = 2'd0,
		AXIS_Y = 2'd1,
		AXIS_Z = 2'd2
	} axis_t;

	typedef enum logic [1:0] {
		DIV_TX0 = 2'd0,
		DIV_TX1 = 2'd1,
		DIV_TY0 = 2'd2,
		DIV_TY1 = 2'd3
	} div_sel_t;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} vec3_t;

	typedef struct packed {
		logic       load_corner;
		logic       cap_cell;
		logic       div_start;
		div_sel_t   div_sel;
		logic       lerp_issue;
		lerp_kind_t kind;
		axis_t      axis;
		logic [2:0] vert_idx;
		logic       out_load;
		logic       out_err;
		logic       out_last;
	} ctrl_cmd_t;

	typedef struct packed {
		logic cell_err;
		logic div_done;
		logic out_free;
	} dp_sts_t;

	function automatic logic signed [31:0] pick_axis(vec3_t v, axis_t a);
		logic signed [31:0] r;
		case (a)
			AXIS_X: r = v.x;
			AXIS_Y: r = v.y;
			AXIS_Z: r = v.z;
			default: r = v.x;
		endcase
		return r;
	endfunction

	function automatic vec3_t put_axis(vec3_t v, axis_t a, logic signed [31:0] val);
		vec3_t r;
		r = v;
		case (a)
			AXIS_X: r.x = val;
			AXIS_Y: r.y = val;
			AXIS_Z: r.z = val;
			default: r = v;
		endcase
		return r;
	endfunction

	function automatic logic vert_dc(logic odd, logic [2:0] k);
		logic r;
		if (k < 3'(NUM_VERTS)) begin
			r = odd ? ODD_DC[k] : EVEN_DC[k];
		end else begin
			r = 1'b0;
		end
		return r;
	endfunction

	function automatic logic vert_dr(logic odd, logic [2:0] k);
		logic r;
		if (k < 3'(NUM_VERTS)) begin
			r = odd ? ODD_DR[k] : EVEN_DR[k];
		end else begin
			r = 1'b0;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: design/bpt_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bpt_div
// Restoring divider for blend factors: floor(i * 2^FRAC_BITS / d), one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
module bpt_div #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [7:0]         dividend,
	input  wire logic [7:0]         divisor,
	output logic                    done,
	output logic [FRAC_BITS:0]      quot
);

	localparam int DW = 8 + FRAC_BITS;
	localparam int CW = $clog2(DW + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [7:0]    rem_q;
	logic [7:0]    div_q;
	logic [DW-1:0] num_q;

	logic [8:0] rem_sh;
	logic       ge;
	logic [8:0] rem_nx;

	assign rem_sh = {rem_q, num_q[DW-1]};
	assign ge     = rem_sh >= {1'b0, div_q};
	assign rem_nx = ge ? (rem_sh - {1'b0, div_q}) : rem_sh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CW'(DW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CW'(1);
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= {dividend, FRAC_BITS'(0)};
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			// remainder stays below the divisor, so eight bits hold it
			rem_q <= rem_nx[7:0];
			num_q <= {num_q[DW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = num_q[FRAC_BITS:0];

endmodule
`default_nettype wire

FILE: design/bpt_lerp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bpt_lerp
// Two-stage fixed-point blend: a + floor((b - a) * t / 2^FRAC_BITS),
// saturated to 32 bits. One blend may start every cycle.
// ----------------------------------------------------------------------------
module bpt_lerp #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                issue,
	input  wire logic signed [31:0]  a,
	input  wire logic signed [31:0]  b,
	input  wire logic [FRAC_BITS:0]  t,
	output logic                     valid,
	output logic signed [31:0]       res
);

	localparam int PW = 33 + FRAC_BITS + 2;

	logic signed [32:0]    diff;
	logic signed [PW-1:0]  prod;
	logic signed [PW-1:0]  p_s1;
	logic signed [31:0]    a_s1;
	logic                  valid_s1;
	logic signed [PW-1:0]  sum;
	logic                  fits;

	assign diff = {b[31], b} - {a[31], a};
	assign prod = diff * $signed({1'b0, t});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			p_s1 <= prod;
			a_s1 <= a;
		end
	end

	// arithmetic shift gives the floor toward minus infinity
	assign sum  = $signed({{(PW-32){a_s1[31]}}, a_s1}) + (p_s1 >>> FRAC_BITS);
	assign fits = (sum[PW-1:31] == '0) || (sum[PW-1:31] == '1);

	always_comb begin
		if (fits) begin
			res = sum[31:0];
		end else if (sum[PW-1]) begin
			res = 32'sh8000_0000;
		end else begin
			res = 32'sh7fff_ffff;
		end
	end

	assign valid = valid_s1;

endmodule
`default_nettype wire

FILE: design/bpt_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bpt_datapath
// Corner and grid registers, blend factor divider, blend unit, vertex
// registers and the result output register.
// ----------------------------------------------------------------------------
module bpt_datapath #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire bpt_pkg::ctrl_cmd_t cmd,
	output bpt_pkg::dp_sts_t        sts,
	input  wire logic [1:0]         corner_sel,
	input  wire logic signed [31:0] point_x,
	input  wire logic signed [31:0] point_y,
	input  wire logic signed [31:0] point_z,
	input  wire logic [7:0]         cell_col,
	input  wire logic [7:0]         cell_row,
	input  wire logic               cfg_we,
	input  wire logic               cfg_addr,
	input  wire logic [8:0]         cfg_data,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [31:0]      vert_x,
	output logic signed [31:0]      vert_y,
	output logic signed [31:0]      vert_z,
	output logic                    out_last,
	output logic                    out_error
);

	localparam logic [8:0] GRID_LIMIT = 9'(bpt_pkg::MAX_GRID);

	bpt_pkg::vec3_t c00_q, c10_q, c01_q, c11_q;
	bpt_pkg::vec3_t e0_q, e1_q, vtx_q;
	logic [8:0] cols_q, rows_q;
	logic [7:0] col_q, row_q;
	logic [FRAC_BITS:0] tx0_q, tx1_q, ty0_q, ty1_q;

	logic [8:0] cols_m1, rows_m1;
	logic       odd;
	logic [FRAC_BITS:0] tx, ty;

	logic [7:0] div_dividend, div_divisor;
	logic       div_done;
	logic [FRAC_BITS:0] div_quot;

	logic signed [31:0] lerp_a, lerp_b;
	logic [FRAC_BITS:0] lerp_t;
	logic               lerp_valid;
	logic signed [31:0] lerp_res;
	bpt_pkg::lerp_kind_t kind_s1;
	bpt_pkg::axis_t      axis_s1;

	logic           out_valid_q;
	logic           out_last_q, out_error_q;
	bpt_pkg::vec3_t out_q;

	// configuration and corner registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= 9'd2;
			rows_q <= 9'd2;
		end else if (cfg_we) begin
			case (cfg_addr)
				bpt_pkg::CFG_GRID_COLS: cols_q <= cfg_data;
				bpt_pkg::CFG_GRID_ROWS: rows_q <= cfg_data;
				default: cols_q <= cols_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c00_q <= '0;
			c10_q <= '0;
			c01_q <= '0;
			c11_q <= '0;
		end else if (cmd.load_corner) begin
			case (corner_sel)
				bpt_pkg::CORNER_00: c00_q <= '{x: point_x, y: point_y, z: point_z};
				bpt_pkg::CORNER_10: c10_q <= '{x: point_x, y: point_y, z: point_z};
				bpt_pkg::CORNER_01: c01_q <= '{x: point_x, y: point_y, z: point_z};
				bpt_pkg::CORNER_11: c11_q <= '{x: point_x, y: point_y, z: point_z};
				default: c00_q <= c00_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap_cell) begin
			col_q <= cell_col;
			row_q <= cell_row;
		end
	end

	// request check
	assign cols_m1 = cols_q - 9'd1;
	assign rows_m1 = rows_q - 9'd1;
	assign sts.cell_err = (cols_q < 9'd2) || (rows_q < 9'd2) ||
		(cols_q > GRID_LIMIT) || (rows_q > GRID_LIMIT) ||
		({1'b0, col_q} >= cols_m1) || ({1'b0, row_q} >= rows_m1);

	// blend factors of the two columns and two rows of the cell
	always_comb begin
		case (cmd.div_sel)
			bpt_pkg::DIV_TX0: begin
				div_dividend = col_q;
				div_divisor  = cols_m1[7:0];
			end
			bpt_pkg::DIV_TX1: begin
				div_dividend = col_q + 8'd1;
				div_divisor  = cols_m1[7:0];
			end
			bpt_pkg::DIV_TY0: begin
				div_dividend = row_q;
				div_divisor  = rows_m1[7:0];
			end
			bpt_pkg::DIV_TY1: begin
				div_dividend = row_q + 8'd1;
				div_divisor  = rows_m1[7:0];
			end
			default: begin
				div_dividend = col_q;
				div_divisor  = cols_m1[7:0];
			end
		endcase
	end

	bpt_div #(
		.FRAC_BITS(FRAC_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quot     (div_quot)
	);

	assign sts.div_done = div_done;

	always_ff @(posedge clk) begin
		if (div_done) begin
			case (cmd.div_sel)
				bpt_pkg::DIV_TX0: tx0_q <= div_quot;
				bpt_pkg::DIV_TX1: tx1_q <= div_quot;
				bpt_pkg::DIV_TY0: ty0_q <= div_quot;
				bpt_pkg::DIV_TY1: ty1_q <= div_quot;
				default: tx0_q <= div_quot;
			endcase
		end
	end

	// blend operands of the current vertex
	assign odd = col_q[0] ^ row_q[0];
	assign tx  = bpt_pkg::vert_dc(odd, cmd.vert_idx) ? tx1_q : tx0_q;
	assign ty  = bpt_pkg::vert_dr(odd, cmd.vert_idx) ? ty1_q : ty0_q;

	always_comb begin
		case (cmd.kind)
			bpt_pkg::KIND_E0: begin
				lerp_a = bpt_pkg::pick_axis(c00_q, cmd.axis);
				lerp_b = bpt_pkg::pick_axis(c01_q, cmd.axis);
				lerp_t = ty;
			end
			bpt_pkg::KIND_E1: begin
				lerp_a = bpt_pkg::pick_axis(c10_q, cmd.axis);
				lerp_b = bpt_pkg::pick_axis(c11_q, cmd.axis);
				lerp_t = ty;
			end
			bpt_pkg::KIND_FINAL: begin
				lerp_a = bpt_pkg::pick_axis(e0_q, cmd.axis);
				lerp_b = bpt_pkg::pick_axis(e1_q, cmd.axis);
				lerp_t = tx;
			end
			default: begin
				lerp_a = '0;
				lerp_b = '0;
				lerp_t = ty;
			end
		endcase
	end

	bpt_lerp #(
		.FRAC_BITS(FRAC_BITS)
	) u_lerp (
		.clk    (clk),
		.arst_n (arst_n),
		.issue  (cmd.lerp_issue),
		.a      (lerp_a),
		.b      (lerp_b),
		.t      (lerp_t),
		.valid  (lerp_valid),
		.res    (lerp_res)
	);

	always_ff @(posedge clk) begin
		if (cmd.lerp_issue) begin
			kind_s1 <= cmd.kind;
			axis_s1 <= cmd.axis;
		end
	end

	// write back blend results
	always_ff @(posedge clk) begin
		if (lerp_valid) begin
			case (kind_s1)
				bpt_pkg::KIND_E0:    e0_q  <= bpt_pkg::put_axis(e0_q, axis_s1, lerp_res);
				bpt_pkg::KIND_E1:    e1_q  <= bpt_pkg::put_axis(e1_q, axis_s1, lerp_res);
				bpt_pkg::KIND_FINAL: vtx_q <= bpt_pkg::put_axis(vtx_q, axis_s1, lerp_res);
				default:             vtx_q <= vtx_q;
			endcase
		end
	end

	// result register
	assign sts.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q       <= cmd.out_err ? '0 : vtx_q;
			out_last_q  <= cmd.out_last;
			out_error_q <= cmd.out_err;
		end
	end

	assign out_valid = out_valid_q;
	assign vert_x    = out_q.x;
	assign vert_y    = out_q.y;
	assign vert_z    = out_q.z;
	assign out_last  = out_last_q;
	assign out_error = out_error_q;

endmodule
`default_nettype wire

FILE: design/bpt_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bpt_ctrl
// Request sequencer: accepts items, runs the four blend factor divisions,
// issues nine blends per vertex and hands six vertices to the output.
// ----------------------------------------------------------------------------
module bpt_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire logic             in_op,
	output logic                  in_ready,
	output bpt_pkg::ctrl_cmd_t    cmd,
	input  wire bpt_pkg::dp_sts_t sts
);

	typedef enum logic [6:0] {
		ST_IDLE     = 7'b0000001,
		ST_CHECK    = 7'b0000010,
		ST_ERR      = 7'b0000100,
		ST_DIV_GO   = 7'b0001000,
		ST_DIV_WAIT = 7'b0010000,
		ST_CALC     = 7'b0100000,
		ST_EMIT     = 7'b1000000
	} state_t;

	state_t              state_q, state_d;
	bpt_pkg::div_sel_t   div_sel_q, div_sel_d;
	logic [3:0]          step_q, step_d;
	logic [2:0]          vert_q, vert_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			div_sel_q <= bpt_pkg::DIV_TX0;
			step_q    <= '0;
			vert_q    <= '0;
		end else begin
			state_q   <= state_d;
			div_sel_q <= div_sel_d;
			step_q    <= step_d;
			vert_q    <= vert_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		div_sel_d = div_sel_q;
		step_d    = step_q;
		vert_d    = vert_q;
		in_ready  = 1'b0;

		cmd          = '0;
		cmd.div_sel  = div_sel_q;
		cmd.vert_idx = vert_q;
		// blend schedule: e0/e1 pairs for x, y, z, then the three x-direction blends
		if (step_q < 4'(bpt_pkg::PAIR_STEPS)) begin
			cmd.kind = step_q[0] ? bpt_pkg::KIND_E1 : bpt_pkg::KIND_E0;
			cmd.axis = bpt_pkg::axis_t'(step_q[2:1]);
		end else begin
			cmd.kind = bpt_pkg::KIND_FINAL;
			cmd.axis = bpt_pkg::axis_t'(2'(step_q - 4'(bpt_pkg::PAIR_STEPS)));
		end

		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_op == bpt_pkg::OP_LOAD) begin
						cmd.load_corner = 1'b1;
					end else begin
						cmd.cap_cell = 1'b1;
						div_sel_d    = bpt_pkg::DIV_TX0;
						state_d      = ST_CHECK;
					end
				end
			end
			ST_CHECK: begin
				state_d = sts.cell_err ? ST_ERR : ST_DIV_GO;
			end
			ST_ERR: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_err  = 1'b1;
					cmd.out_last = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			ST_DIV_GO: begin
				cmd.div_start = 1'b1;
				state_d       = ST_DIV_WAIT;
			end
			ST_DIV_WAIT: begin
				if (sts.div_done) begin
					if (div_sel_q == bpt_pkg::DIV_TY1) begin
						step_d  = '0;
						vert_d  = '0;
						state_d = ST_CALC;
					end else begin
						div_sel_d = bpt_pkg::div_sel_t'(div_sel_q + 2'd1);
						state_d   = ST_DIV_GO;
					end
				end
			end
			ST_CALC: begin
				cmd.lerp_issue = step_q < 4'(bpt_pkg::ISSUE_STEPS);
				step_d         = step_q + 4'd1;
				// a final step without an issue drains the last blend
				if (step_q == 4'(bpt_pkg::ISSUE_STEPS)) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_last = vert_q == 3'(bpt_pkg::NUM_VERTS - 1);
					if (vert_q == 3'(bpt_pkg::NUM_VERTS - 1)) begin
						state_d = ST_IDLE;
					end else begin
						vert_d  = vert_q + 3'd1;
						step_d  = '0;
						state_d = ST_CALC;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

FILE: design/bilinear_patch_tessellator_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bilinear_patch_tessellator_top
// Tessellates one cell of a bilinear 3D patch into two triangles.
// ----------------------------------------------------------------------------
// Input stream: tuser selects the item. A load (tuser 0) writes one corner
// point and leaves the input ready. A cell request (tuser 1) gives six vertex
// transfers on the output stream, tlast on the sixth; a bad grid size or a
// cell out of range gives one zero vertex with tuser (error) and tlast set.
// Grid size is set through the write port (index 0 columns, 1 rows); the user
// must write it only while no request is in flight, the block does not enforce this.
// A request holds the input until its last vertex is loaded into the output
// register: four serial divisions of FRAC_BITS+8 steps form the blend
// factors, then each vertex takes nine blends through one pipelined
// multiplier plus drain and hand-off. An error request passes the check
// state and then loads its error vertex. The first vertex appears after
// the divisions and the blends of that vertex.
// Reset clears the corners to zero, sets both grid sizes to 2 and empties
// the output register. A stalled output holds its vertex; the sequencer
// waits with the next vertex until the register is free, and after the last
// vertex the input is taken again while that vertex still waits.
// ----------------------------------------------------------------------------
module bilinear_patch_tessellator_top #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// corner_sel, point_x, point_y, point_z, cell_col, cell_row, zero pad
	input  wire logic [119:0] s_axis_tdata,
	// op
	input  wire logic         s_axis_tuser,
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// vert_x, vert_y, vert_z
	output logic [95:0]       m_axis_tdata,
	// error
	output logic              m_axis_tuser,
	output logic              m_axis_tlast,
	input  wire logic         cfg_we,
	input  wire logic         cfg_addr,
	input  wire logic [8:0]   cfg_data
);

	bpt_pkg::ctrl_cmd_t cmd;
	bpt_pkg::dp_sts_t   sts;
	logic               in_ready;
	logic signed [31:0] vert_x, vert_y, vert_z;

	bpt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_op    (s_axis_tuser),
		.in_ready (in_ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	bpt_datapath #(
		.FRAC_BITS(FRAC_BITS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.corner_sel (s_axis_tdata[1:0]),
		.point_x    (s_axis_tdata[33:2]),
		.point_y    (s_axis_tdata[65:34]),
		.point_z    (s_axis_tdata[97:66]),
		.cell_col   (s_axis_tdata[105:98]),
		.cell_row   (s_axis_tdata[113:106]),
		.cfg_we     (cfg_we),
		.cfg_addr   (cfg_addr),
		.cfg_data   (cfg_data),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.vert_x     (vert_x),
		.vert_y     (vert_y),
		.vert_z     (vert_z),
		.out_last   (m_axis_tlast),
		.out_error  (m_axis_tuser)
	);

	assign s_axis_tready = in_ready;
	assign m_axis_tdata  = {vert_z, vert_y, vert_x};

endmodule
`default_nettype wire
